/* rtl/core/pip_pkg.sv */
// shared types and constants for the point-in-polygon test core
// no dependencies; imported by pip_ctrl, pip_datapath and point_in_polygon_test_core

package pip_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int COORD_W      = 32;
  localparam int DIFF_W       = COORD_W + 1;
  localparam int PROD_W       = 2 * DIFF_W;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_TEST   = 2'd2,
    CMD_NONE   = 2'd3
  } pip_cmd_code_t;

  // controller to datapath
  typedef struct packed {
    logic              clear;
    logic              append;
    logic              start;
    logic              rd_en;
    logic              rd_first;
    logic [ADDR_W-1:0] rd_addr;
    logic              load_out;
  } pip_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [CNT_W-1:0] vcount;
    logic             pipe_busy;
  } pip_status_t;

endpackage

/* rtl/core/pip_ctrl.sv */
// controller state machine for the point-in-polygon test core
// depends on pip_pkg; drives pip_datapath through pip_cmd_t

module pip_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_command,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  pip_pkg::pip_status_t status,
  output pip_pkg::pip_cmd_t    cmd
);
  import pip_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_WALK  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } pip_state_t;

  pip_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] iss_r, iss_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             last_read;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign last_read = (iss_r == status.vcount);

  always_comb begin
    state_nxt     = state_r;
    iss_nxt       = iss_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (pip_cmd_code_t'(in_command))
            CMD_CLEAR:  cmd.clear = 1'b1;
            CMD_APPEND: cmd.append = 1'b1;
            CMD_TEST: begin
              cmd.start = 1'b1;
              iss_nxt   = '0;
              // empty polygon reports outside straight away
              state_nxt = (status.vcount == '0) ? ST_DONE : ST_WALK;
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        // vertex 0 first, then 1 .. n-1, then vertex 0 again to close
        cmd.rd_en    = 1'b1;
        cmd.rd_first = (iss_r == '0);
        cmd.rd_addr  = last_read ? '0 : iss_r[ADDR_W-1:0];
        iss_nxt      = iss_r + 1'b1;
        if (last_read) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      iss_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iss_r       <= iss_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/core/pip_datapath.sv */
// vertex memory and edge-crossing pipeline for the point-in-polygon test core
// depends on pip_pkg; commanded by pip_ctrl

module pip_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic signed [pip_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [pip_pkg::COORD_W-1:0] in_coord_y,
  input  pip_pkg::pip_cmd_t                  cmd,
  output pip_pkg::pip_status_t               status,
  output logic                               inside_res
);
  import pip_pkg::*;

  logic [COORD_W-1:0] mem_x [MAX_VERTICES];
  logic [COORD_W-1:0] mem_y [MAX_VERTICES];

  logic [CNT_W-1:0] vcount_r;

  logic signed [COORD_W-1:0] px_r, py_r;
  logic signed [COORD_W-1:0] rd_x_r, rd_y_r;
  logic signed [COORD_W-1:0] prev_x_r, prev_y_r;
  logic                      v1_r, first1_r;

  logic signed [DIFF_W-1:0] a_r, b_r, c_r, d_r;
  logic                     cond2_r, dyneg2_r, v2_r;

  logic signed [PROD_W-1:0] p1_r, p2_r;
  logic                     cond3_r, dyneg3_r, v3_r;

  logic hit_r, parity_r, inside_r;

  logic signed [COORD_W-1:0] xhi;
  logic                      y_up, in_span, cond1;
  logic                      prod_eq, prod_gt;

  // vertex store, write on append while not full
  always_ff @(posedge clk) begin
    if (cmd.append && (vcount_r < CNT_W'(MAX_VERTICES))) begin
      mem_x[vcount_r[ADDR_W-1:0]] <= in_coord_x;
      mem_y[vcount_r[ADDR_W-1:0]] <= in_coord_y;
    end
    if (cmd.rd_en) begin
      rd_x_r <= mem_x[cmd.rd_addr];
      rd_y_r <= mem_y[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= '0;
    end else if (cmd.clear) begin
      vcount_r <= '0;
    end else if (cmd.append && (vcount_r < CNT_W'(MAX_VERTICES))) begin
      vcount_r <= vcount_r + 1'b1;
    end
  end

  // edge test, previous vertex against the one just read
  always_comb begin
    y_up    = prev_y_r < rd_y_r;
    in_span = y_up ? ((py_r >= prev_y_r) && (py_r < rd_y_r))
                   : ((py_r >= rd_y_r) && (py_r < prev_y_r));
    xhi     = (prev_x_r > rd_x_r) ? prev_x_r : rd_x_r;
    cond1   = in_span && (px_r <= xhi);
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      px_r <= in_coord_x;
      py_r <= in_coord_y;
    end
    if (v1_r) begin
      prev_x_r <= rd_x_r;
      prev_y_r <= rd_y_r;
    end
    a_r      <= DIFF_W'(py_r) - DIFF_W'(prev_y_r);
    b_r      <= DIFF_W'(rd_x_r) - DIFF_W'(prev_x_r);
    c_r      <= DIFF_W'(px_r) - DIFF_W'(prev_x_r);
    d_r      <= DIFF_W'(rd_y_r) - DIFF_W'(prev_y_r);
    cond2_r  <= cond1;
    dyneg2_r <= rd_y_r < prev_y_r;
    p1_r     <= PROD_W'(a_r) * PROD_W'(b_r);
    p2_r     <= PROD_W'(c_r) * PROD_W'(d_r);
    cond3_r  <= cond2_r;
    dyneg3_r <= dyneg2_r;
  end

  // sign of (crossing x - px) is sign(p1 - p2) flipped when dy is negative
  assign prod_eq = (p1_r == p2_r);
  assign prod_gt = (p1_r > p2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      first1_r <= 1'b0;
      v2_r     <= 1'b0;
      v3_r     <= 1'b0;
      hit_r    <= 1'b0;
      parity_r <= 1'b0;
    end else begin
      v1_r     <= cmd.rd_en;
      first1_r <= cmd.rd_first;
      v2_r     <= v1_r && !first1_r;
      v3_r     <= v2_r;
      if (cmd.start) begin
        hit_r    <= 1'b0;
        parity_r <= 1'b0;
      end else if (v3_r && cond3_r) begin
        hit_r    <= hit_r | prod_eq;
        parity_r <= parity_r ^ (!prod_eq && (prod_gt ^ dyneg3_r));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      inside_r <= hit_r | parity_r;
    end
  end

  assign status.vcount    = vcount_r;
  assign status.pipe_busy = v1_r | v2_r | v3_r;
  assign inside_res       = inside_r;

endmodule

/* rtl/core/point_in_polygon_test_core.sv */
// Point-in-polygon test core: holds a polygon of up to 64 Q16.16 vertices and answers
// even-odd ray-casting tests. Clear and append commands give no result; appends past 64
// vertices are dropped. In a test of a polygon with n vertices, the single read port of
// the vertex memory walks one edge per cycle (n + 1 reads, closing back to vertex 0),
// followed by three pipeline stages (differences, products, exact compare). A point
// exactly on a counted edge reports inside; an empty polygon reports outside. A finished
// result waits in an output register, so the next command is taken while it is still
// pending.
// Depends on pip_pkg, pip_ctrl and pip_datapath.

module point_in_polygon_test_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_command,
  input  logic signed [pip_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [pip_pkg::COORD_W-1:0] in_coord_y,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_inside_res
);
  import pip_pkg::*;

  pip_cmd_t    cmd;
  pip_status_t status;

  pip_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .cmd        (cmd)
  );

  pip_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_coord_x (in_coord_x),
    .in_coord_y (in_coord_y),
    .cmd        (cmd),
    .status     (status),
    .inside_res (out_inside_res)
  );

endmodule
